// File: src/rtpc_pkg.sv
`timescale 1ns / 1ps
package rtpc_pkg;

   // Fixed sizes of the pool
   localparam int SLOTS        = 64;
   localparam int SLOT_BITS    = 6;
   localparam int ROUND_PIXELS = 32;
   localparam int DIM_W        = 15;
   localparam int KEY_W        = 27;
   localparam int ORD_W        = KEY_W + 2 * DIM_W;
   localparam int BYTES_W      = 48;
   localparam int AGE_W        = 32;
   localparam int CNT_W        = 7;
   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 96;
   localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'((32767 / ROUND_PIXELS) * ROUND_PIXELS);

   // Commands carried in req_tuser
   localparam logic [1:0] CMD_GET = 2'd0;
   localparam logic [1:0] CMD_PUT = 2'd1;
   localparam logic [1:0] CMD_GC  = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_FREE  = 2'd1;
   localparam logic [1:0] STAT_BAD_PUT  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_FREE  = 2'd0;
   localparam logic [1:0] CSR_MAX_BYTES = 2'd1;
   localparam logic [1:0] CSR_MAX_AGE   = 2'd2;

   typedef enum logic [1:0] {
      SCAN_LOOKUP,
      SCAN_OLDEST,
      SCAN_PURGE
   } scan_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK_GO,
      ST_LOOK_WAIT,
      ST_GET_MUL,
      ST_GET_DECIDE,
      ST_GET_WRITE,
      ST_PUT,
      ST_GC_CHECK,
      ST_OLD_WAIT,
      ST_GC_EVICT,
      ST_PURGE_GO,
      ST_PURGE_WAIT,
      ST_GC_FINISH,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          mul_get;
      logic          take_hit;
      logic          calc_bytes;
      logic          alloc;
      logic          no_free;
      logic          put_do;
      logic          evict;
      logic          purge_arm;
      logic          count_down;
      logic          frame_tick;
      logic          respond;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_busy;
      logic hit;
      logic free_found;
      logic gc_over;
      logic oldest_fresh;
      logic purge_due;
      logic out_free;
   } dp_stat_type;

   // Round a dimension up to the pixel grid, clamped to what fits in 15 bits
   function automatic logic [DIM_W-1:0] round_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W:0] sum;
      begin
         sum = {1'b0, v} + (DIM_W+1)'(ROUND_PIXELS - 1);
         sum = sum & ~((DIM_W+1)'(ROUND_PIXELS - 1));
         if (sum[DIM_W]) begin
            round_dim = DIM_CLAMP;
         end else begin
            round_dim = sum[DIM_W-1:0];
         end
      end
   endfunction

endpackage

// File: src/rtpc_ctrl.sv
`timescale 1ns / 1ps
module rtpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  rtpc_pkg::dp_stat_type stat,
   output rtpc_pkg::dp_cmd_type  cmd
);
   import rtpc_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.scan_mode = SCAN_LOOKUP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               priority case (req_tuser)
                  CMD_GET: state_in = ST_LOOK_GO;
                  CMD_PUT: state_in = ST_PUT;
                  CMD_GC:  state_in = ST_GC_CHECK;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_LOOK_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode = SCAN_LOOKUP;
            state_in = ST_LOOK_WAIT;
         end
         ST_LOOK_WAIT: begin
            if (!stat.scan_busy) begin
               state_in = ST_GET_MUL;
            end
         end
         ST_GET_MUL: begin
            cmd.mul_get = 1'b1;
            state_in = ST_GET_DECIDE;
         end
         ST_GET_DECIDE: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               state_in = ST_DONE;
            end else if (stat.free_found) begin
               cmd.calc_bytes = 1'b1;
               state_in = ST_GET_WRITE;
            end else begin
               cmd.no_free = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_GET_WRITE: begin
            cmd.alloc = 1'b1;
            state_in = ST_DONE;
         end
         ST_PUT: begin
            cmd.put_do = 1'b1;
            state_in = ST_DONE;
         end
         ST_GC_CHECK: begin
            if (stat.gc_over) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode = SCAN_OLDEST;
               state_in = ST_OLD_WAIT;
            end else begin
               state_in = ST_PURGE_GO;
            end
         end
         ST_OLD_WAIT: begin
            if (!stat.scan_busy) begin
               state_in = ST_GC_EVICT;
            end
         end
         ST_GC_EVICT: begin
            if (stat.oldest_fresh) begin
               state_in = ST_PURGE_GO;
            end else begin
               cmd.evict = 1'b1;
               state_in = ST_GC_CHECK;
            end
         end
         ST_PURGE_GO: begin
            if (stat.purge_due) begin
               cmd.purge_arm = 1'b1;
               cmd.scan_start = 1'b1;
               cmd.scan_mode = SCAN_PURGE;
               state_in = ST_PURGE_WAIT;
            end else begin
               cmd.count_down = 1'b1;
               state_in = ST_GC_FINISH;
            end
         end
         ST_PURGE_WAIT: begin
            if (!stat.scan_busy) begin
               state_in = ST_GC_FINISH;
            end
         end
         ST_GC_FINISH: begin
            cmd.frame_tick = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.respond = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/rtpc_dp.sv
`timescale 1ns / 1ps
module rtpc_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [rtpc_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_index,
   input  logic [rtpc_pkg::BYTES_W-1:0]          csr_wdata,
   input  rtpc_pkg::dp_cmd_type                  cmd,
   output rtpc_pkg::dp_stat_type                 stat,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rtpc_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [1:0]                            rsp_tuser
);
   import rtpc_pkg::*;

   localparam int REC_W = ORD_W + BYTES_W;

   // Configuration registers
   logic [CNT_W-1:0]   max_free_ff;
   logic [BYTES_W-1:0] max_bytes_ff;
   logic [AGE_W-1:0]   max_age_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_free_ff  <= CNT_W'(16);
         max_bytes_ff <= BYTES_W'(16777216);
         max_age_ff   <= AGE_W'(30);
      end else if (csr_wr_en) begin
         priority case (csr_index)
            CSR_MAX_FREE:  max_free_ff  <= csr_wdata[CNT_W-1:0];
            CSR_MAX_BYTES: max_bytes_ff <= csr_wdata;
            CSR_MAX_AGE:   max_age_ff   <= csr_wdata[AGE_W-1:0];
            default: ;
         endcase
      end
   end

   // Latched request
   logic [KEY_W-1:0]     key_ff;
   logic [DIM_W-1:0]     tw_ff, th_ff;
   logic [13:0]          per_samp_ff;
   logic [SLOT_BITS-1:0] put_h_ff;
   logic [2:0]           l_attach;
   logic [7:0]           l_samples;
   logic [5:0]           l_per;

   always_comb begin
      l_attach  = req_tdata[2:0];
      l_samples = (req_tdata[40:33] == 8'd0) ? 8'd1 : req_tdata[40:33];
      l_per     = (l_attach[0] ? {1'b0, req_tdata[61:57]} : 6'd0)
                + (l_attach[1] ? 6'd3 : 6'd0) + (l_attach[2] ? 6'd1 : 6'd0);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff      <= {l_attach, l_samples, req_tdata[48:41], req_tdata[56:49]};
         tw_ff       <= round_dim(req_tdata[17:3]);
         th_ff       <= round_dim(req_tdata[32:18]);
         per_samp_ff <= l_per * l_samples;
         put_h_ff    <= req_tdata[67:62];
      end
   end

   // Pool state held in flops
   logic [SLOTS-1:0]   live_ff, live_in;
   logic [SLOTS-1:0]   pooled_ff, pooled_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTES_W-1:0] live_bytes_ff, live_bytes_in;
   logic [AGE_W-1:0]   frame_age_ff;
   logic [AGE_W-1:0]   countdown_ff;
   logic [AGE_W-1:0]   put_seq_ff;
   logic [AGE_W-1:0]   limit_ff;

   // Per-slot memories
   logic [REC_W-1:0]   rec_mem [SLOTS];
   logic [AGE_W-1:0]   age_mem [SLOTS];
   logic [AGE_W-1:0]   po_mem  [SLOTS];
   logic [REC_W-1:0]   rd_rec_ff;
   logic [AGE_W-1:0]   rd_age_ff;
   logic [AGE_W-1:0]   rd_po_ff;

   // Scan sequencer
   logic [SLOT_BITS:0]   idx_ff;
   logic                 run_ff;
   logic                 rd_valid_ff;
   logic [SLOT_BITS-1:0] rd_idx_ff;
   scan_mode_type        mode_ff;

   // Best candidate of the scan
   logic                 found_ff;
   logic [SLOT_BITS-1:0] best_idx_ff;
   logic [ORD_W-1:0]     best_ord_ff;
   logic [AGE_W-1:0]     best_age_ff;
   logic [BYTES_W-1:0]   best_bytes_ff;
   logic [AGE_W-1:0]     best_po_ff;
   logic                 free_found_ff;
   logic [SLOT_BITS-1:0] free_idx_ff;

   // Products for the fit test and the byte size
   logic [2*DIM_W-1:0]   prod_best_ff, prod_req_ff;
   logic [BYTES_W-1:0]   new_bytes_ff;

   // Result registers
   logic [SLOT_BITS-1:0] res_handle_ff;
   logic                 res_reused_ff;
   logic [1:0]           res_status_ff;
   logic [DIM_W-1:0]     res_w_ff, res_h_ff;
   logic [CNT_W-1:0]     evicted_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [1:0]           rsp_user_ff;

   // Fields of the slot under evaluation
   logic [ORD_W-1:0]   s_ord;
   logic [BYTES_W-1:0] s_bytes;
   logic               s_pooled, s_live;
   logic [ORD_W-1:0]   req_ord;
   logic               s_before;
   logic               s_cand;
   logic               s_purge;

   always_comb begin
      s_ord    = rd_rec_ff[REC_W-1:BYTES_W];
      s_bytes  = rd_rec_ff[BYTES_W-1:0];
      s_pooled = pooled_ff[rd_idx_ff];
      s_live   = live_ff[rd_idx_ff];
      req_ord  = {key_ff, tw_ff, th_ff};
      s_before = (s_ord < best_ord_ff) || ((s_ord == best_ord_ff) && (rd_po_ff > best_po_ff));
      s_cand   = 1'b0;
      s_purge  = 1'b0;
      unique case (mode_ff)
         SCAN_LOOKUP: s_cand = s_pooled && (s_ord >= req_ord) && (!found_ff || s_before);
         SCAN_OLDEST: s_cand = s_pooled && (!found_ff || (rd_age_ff < best_age_ff)
                               || ((rd_age_ff == best_age_ff) && s_before));
         SCAN_PURGE:  s_purge = s_pooled && (rd_age_ff <= limit_ff);
         default: ;
      endcase
   end

   // Scan address counter and registered memory reads
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
         idx_ff      <= '0;
         mode_ff     <= SCAN_LOOKUP;
      end else if (cmd.scan_start) begin
         run_ff      <= 1'b1;
         rd_valid_ff <= 1'b0;
         idx_ff      <= '0;
         mode_ff     <= cmd.scan_mode;
      end else if (run_ff) begin
         if (idx_ff == (SLOT_BITS+1)'(SLOTS)) begin
            run_ff      <= 1'b0;
            rd_valid_ff <= 1'b0;
         end else begin
            rd_valid_ff <= 1'b1;
            idx_ff      <= idx_ff + 1'b1;
         end
      end else begin
         rd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[SLOT_BITS-1:0];
      rd_rec_ff <= rec_mem[idx_ff[SLOT_BITS-1:0]];
      rd_age_ff <= age_mem[idx_ff[SLOT_BITS-1:0]];
      rd_po_ff  <= po_mem[idx_ff[SLOT_BITS-1:0]];
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         rec_mem[free_idx_ff] <= {key_ff, tw_ff, th_ff, new_bytes_ff};
      end
      if (cmd.alloc || cmd.take_hit) begin
         age_mem[cmd.alloc ? free_idx_ff : best_idx_ff] <= frame_age_ff;
      end
      if (cmd.put_do && live_ff[put_h_ff] && !pooled_ff[put_h_ff]) begin
         po_mem[put_h_ff] <= put_seq_ff;
      end
   end

   // Candidate tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (rd_valid_ff) begin
         if (s_cand) begin
            found_ff <= 1'b1;
         end
         if ((mode_ff == SCAN_LOOKUP) && !s_live && !free_found_ff) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff && s_cand) begin
         best_idx_ff   <= rd_idx_ff;
         best_ord_ff   <= s_ord;
         best_age_ff   <= rd_age_ff;
         best_bytes_ff <= s_bytes;
         best_po_ff    <= rd_po_ff;
      end
      if (rd_valid_ff && (mode_ff == SCAN_LOOKUP) && !s_live && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.mul_get) begin
         prod_best_ff <= best_ord_ff[2*DIM_W-1:DIM_W] * best_ord_ff[DIM_W-1:0];
         prod_req_ff  <= tw_ff * th_ff;
      end
      if (cmd.calc_bytes) begin
         new_bytes_ff <= BYTES_W'(per_samp_ff * prod_req_ff);
      end
      if (cmd.purge_arm) begin
         limit_ff <= frame_age_ff - max_age_ff;
      end
   end

   // Fit test of the lookup candidate
   logic [2*DIM_W+1:0] lhs3, rhs3;
   logic               hit;

   always_comb begin
      lhs3 = {1'b0, prod_best_ff, 1'b0};
      rhs3 = {2'b00, prod_req_ff} + {1'b0, prod_req_ff, 1'b0};
      hit  = found_ff && (best_ord_ff[ORD_W-1:2*DIM_W] == key_ff)
          && (best_ord_ff[2*DIM_W-1:DIM_W] >= tw_ff) && (best_ord_ff[DIM_W-1:0] >= th_ff)
          && (lhs3 < rhs3);
   end

   // Next values of the pool flops
   always_comb begin
      live_in       = live_ff;
      pooled_in     = pooled_ff;
      count_in      = count_ff;
      live_bytes_in = live_bytes_ff;
      if (rd_valid_ff && s_purge) begin
         live_in[rd_idx_ff]   = 1'b0;
         pooled_in[rd_idx_ff] = 1'b0;
         count_in             = count_ff - 1'b1;
         live_bytes_in        = live_bytes_ff - s_bytes;
      end
      if (cmd.evict) begin
         live_in[best_idx_ff]   = 1'b0;
         pooled_in[best_idx_ff] = 1'b0;
         count_in               = count_ff - 1'b1;
         live_bytes_in          = live_bytes_ff - best_bytes_ff;
      end
      if (cmd.take_hit) begin
         pooled_in[best_idx_ff] = 1'b0;
         count_in               = count_ff - 1'b1;
      end
      if (cmd.alloc) begin
         live_in[free_idx_ff]   = 1'b1;
         pooled_in[free_idx_ff] = 1'b0;
         live_bytes_in          = live_bytes_ff + new_bytes_ff;
      end
      if (cmd.put_do && live_ff[put_h_ff] && !pooled_ff[put_h_ff]) begin
         pooled_in[put_h_ff] = 1'b1;
         count_in            = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         pooled_ff     <= '0;
         count_ff      <= '0;
         live_bytes_ff <= '0;
         frame_age_ff  <= '0;
         countdown_ff  <= AGE_W'(30);
         put_seq_ff    <= '0;
      end else begin
         live_ff       <= live_in;
         pooled_ff     <= pooled_in;
         count_ff      <= count_in;
         live_bytes_ff <= live_bytes_in;
         if (cmd.frame_tick) begin
            frame_age_ff <= frame_age_ff + 1'b1;
         end
         if (cmd.purge_arm) begin
            countdown_ff <= max_age_ff;
         end else if (cmd.count_down) begin
            countdown_ff <= countdown_ff - 1'b1;
         end
         if (cmd.put_do && live_ff[put_h_ff] && !pooled_ff[put_h_ff]) begin
            put_seq_ff <= put_seq_ff + 1'b1;
         end
      end
   end

   // Result fields gathered over the command
   always_ff @(posedge clock) begin
      if (load) begin
         res_handle_ff <= '0;
         res_reused_ff <= 1'b0;
         res_status_ff <= STAT_OK;
         res_w_ff      <= '0;
         res_h_ff      <= '0;
         evicted_ff    <= '0;
      end else begin
         if (cmd.take_hit) begin
            res_handle_ff <= best_idx_ff;
            res_reused_ff <= 1'b1;
            res_w_ff      <= best_ord_ff[2*DIM_W-1:DIM_W];
            res_h_ff      <= best_ord_ff[DIM_W-1:0];
         end
         if (cmd.alloc) begin
            res_handle_ff <= free_idx_ff;
            res_w_ff      <= tw_ff;
            res_h_ff      <= th_ff;
         end
         if (cmd.no_free) begin
            res_status_ff <= STAT_NO_FREE;
         end
         if (cmd.put_do) begin
            res_handle_ff <= put_h_ff;
            if (!(live_ff[put_h_ff] && !pooled_ff[put_h_ff])) begin
               res_status_ff <= STAT_BAD_PUT;
            end
         end
         if (cmd.evict || (rd_valid_ff && s_purge)) begin
            evicted_ff <= evicted_ff + 1'b1;
         end
      end
   end

   // Output register: a result waits here until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_data_ff <= {4'd0, live_bytes_ff, evicted_ff, res_h_ff, res_w_ff,
                         res_reused_ff, res_handle_ff};
         rsp_user_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Status to the controller
   always_comb begin
      stat.scan_busy    = run_ff || rd_valid_ff;
      stat.hit          = hit;
      stat.free_found   = free_found_ff;
      stat.gc_over      = (count_ff != '0)
                       && ((count_ff > max_free_ff) || (live_bytes_ff > max_bytes_ff));
      stat.oldest_fresh = !found_ff || (best_age_ff == frame_age_ff);
      stat.purge_due    = (countdown_ff == '0);
      stat.out_free     = !rsp_valid_ff || rsp_tready;
   end

endmodule

// File: src/render_target_pool_cache_top.sv
`timescale 1ns / 1ps
// One command at a time; each get, and each oldest-entry search or purge of a gc pass, walks
// all 64 slots through the slot memory read port, one slot a cycle, so those walks set the
// throughput.
// The result sits in an output register, so the next command waits only for its transfer.
// Reset is synchronous and active high: the pool empties and the registers take defaults.
module render_target_pool_cache_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // attach_mask, req_width, req_height, sample_count, pixel_format,
   // usage_flags, texel_bytes, return_handle
   input  logic [rtpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // handle, reused, granted_width, granted_height, evicted_count, total_bytes
   output logic [rtpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [rtpc_pkg::BYTES_W-1:0]        csr_wdata
);
   import rtpc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        load;

   assign load = req_tvalid && req_tready;

   rtpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   rtpc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: test/render_target_pool_cache_top_tb.sv
`timescale 1ns / 1ps
module render_target_pool_cache_top_tb;
   import rtpc_pkg::*;

   localparam int          CYCLE_LIMIT = 40000000;
   localparam int          NUM_PHASES  = 5;
   localparam int          PHASE_ITEMS = 280;
   localparam logic [47:0] BYTE_MASK   = 48'hFFFF_FFFF_FFFF;
   localparam logic [1:0]  CMD_BAD     = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  attach_mask;
      logic [14:0] width;
      logic [14:0] height;
      logic [7:0]  samples;
      logic [7:0]  format;
      logic [7:0]  flags;
      logic [4:0]  texel_bytes;
      logic [5:0]  ret_handle;
   } surf_cmd_type;

   typedef struct packed {
      logic [5:0]  handle;
      logic        reused;
      logic [1:0]  status;
      logic [14:0] granted_w;
      logic [14:0] granted_h;
      logic [6:0]  evicted;
      logic [47:0] total;
   } surf_rsp_type;

   typedef struct {
      surf_cmd_type cmd;
      bit           typed;
      surf_rsp_type rsp;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_wr_en;
   logic [1:0]            csr_index;
   logic [BYTES_W-1:0]    csr_wdata;

   render_target_pool_cache_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow copy of the pool, updated on every accepted request transfer.
   bit          pool_live   [SLOTS];
   bit          pool_free   [SLOTS];
   logic [26:0] pool_key    [SLOTS];
   logic [14:0] pool_w      [SLOTS];
   logic [14:0] pool_h      [SLOTS];
   logic [31:0] pool_age    [SLOTS];
   logic [47:0] pool_bytes  [SLOTS];
   logic [31:0] pool_order  [SLOTS];
   logic [47:0] live_total;
   logic [31:0] frame_cnt;
   logic [31:0] purge_cnt;
   logic [31:0] put_seq;
   logic [6:0]  lim_free;
   logic [47:0] lim_bytes;
   logic [31:0] lim_age;

   surf_rsp_type   pending_rsp[$];
   table_row_type  dir_rows[$];
   int          error_count = 0;
   int          items_left  = 0;
   int          tbl_pos     = 0;
   bit          use_table   = 1'b0;
   bit          fill_mode   = 1'b0;
   bit          idle_on     = 1'b1;
   bit          hold_req    = 1'b0;
   int          cycle_count = 0;

   function automatic logic [56:0] pool_rank(logic [26:0] k, logic [14:0] w, logic [14:0] h);
      return {k, w, h};
   endfunction

   // True when slot a is ahead of slot b in pool order.
   function automatic bit slot_ahead(int a, int b);
      logic [56:0] ra, rb;
      ra = pool_rank(pool_key[a], pool_w[a], pool_h[a]);
      rb = pool_rank(pool_key[b], pool_w[b], pool_h[b]);
      if (ra != rb) return ra < rb;
      return pool_order[a] > pool_order[b];
   endfunction

   function automatic logic [14:0] snap_dim(logic [14:0] v);
      int r;
      r = ((int'(v) + 31) / 32) * 32;
      if (r > 32767) r = 32736;
      return 15'(r);
   endfunction

   function automatic void drop_slot(int s);
      live_total   = (live_total - pool_bytes[s]) & BYTE_MASK;
      pool_live[s] = 1'b0;
      pool_free[s] = 1'b0;
   endfunction

   function automatic void pool_reset();
      foreach (pool_live[s]) begin
         pool_live[s] = 1'b0;
         pool_free[s] = 1'b0;
      end
      live_total = '0;
      frame_cnt  = '0;
      put_seq    = '0;
      lim_free   = 7'd16;
      lim_bytes  = 48'd16777216;
      lim_age    = 32'd30;
      purge_cnt  = lim_age;
   endfunction

   // Works out the response to one command and moves the shadow pool on.
   function automatic surf_rsp_type pool_apply(surf_cmd_type c);
      surf_rsp_type r;
      logic [14:0] tw, th;
      logic [7:0]  smp;
      logic [26:0] k;
      logic [56:0] want;
      int          best, slot, oldest, count;
      longint unsigned per, area_have, area_want;
      logic [31:0] cutoff;
      r = '0;
      if (c.command == CMD_GET) begin
         tw   = snap_dim(c.width);
         th   = snap_dim(c.height);
         smp  = (c.samples == 0) ? 8'd1 : c.samples;
         k    = {c.attach_mask, smp, c.format, c.flags};
         want = pool_rank(k, tw, th);
         best = -1;
         for (int s = 0; s < SLOTS; s++) begin
            if (pool_free[s] && pool_rank(pool_key[s], pool_w[s], pool_h[s]) >= want &&
                (best < 0 || slot_ahead(s, best)))
               best = s;
         end
         if (best >= 0) begin
            area_have = 2 * longint'(pool_w[best]) * longint'(pool_h[best]);
            area_want = 3 * longint'(tw) * longint'(th);
         end
         if (best >= 0 && pool_key[best] == k && pool_w[best] >= tw &&
             pool_h[best] >= th && area_have < area_want) begin
            pool_free[best] = 1'b0;
            pool_age[best]  = frame_cnt;
            r.handle    = 6'(best);
            r.reused    = 1'b1;
            r.granted_w = pool_w[best];
            r.granted_h = pool_h[best];
         end else begin
            slot = -1;
            for (int s = 0; s < SLOTS; s++) begin
               if (!pool_live[s]) begin
                  slot = s;
                  break;
               end
            end
            if (slot < 0) begin
               r.status = STAT_NO_FREE;
            end else begin
               per = 0;
               if (c.attach_mask[0]) per += c.texel_bytes;
               if (c.attach_mask[1]) per += 3;
               if (c.attach_mask[2]) per += 1;
               pool_live[slot]  = 1'b1;
               pool_free[slot]  = 1'b0;
               pool_key[slot]   = k;
               pool_w[slot]     = tw;
               pool_h[slot]     = th;
               pool_age[slot]   = frame_cnt;
               pool_bytes[slot] = 48'(per * smp * tw * th);
               live_total       = (live_total + pool_bytes[slot]) & BYTE_MASK;
               r.handle    = 6'(slot);
               r.granted_w = tw;
               r.granted_h = th;
            end
         end
      end else if (c.command == CMD_PUT) begin
         r.handle = c.ret_handle;
         if (pool_live[c.ret_handle] && !pool_free[c.ret_handle]) begin
            pool_free[c.ret_handle]  = 1'b1;
            pool_order[c.ret_handle] = put_seq;
            put_seq++;
         end else begin
            r.status = STAT_BAD_PUT;
         end
      end else if (c.command == CMD_GC) begin
         count = 0;
         foreach (pool_free[s]) if (pool_free[s]) count++;
         while (count > 0 && (count > lim_free || live_total > lim_bytes)) begin
            oldest = -1;
            for (int s = 0; s < SLOTS; s++) begin
               if (pool_free[s] && (oldest < 0 || pool_age[s] < pool_age[oldest] ||
                   (pool_age[s] == pool_age[oldest] && slot_ahead(s, oldest))))
                  oldest = s;
            end
            if (oldest < 0 || pool_age[oldest] == frame_cnt) break;
            drop_slot(oldest);
            r.evicted++;
            count--;
         end
         if (purge_cnt == 0) begin
            cutoff    = frame_cnt - lim_age;
            purge_cnt = lim_age;
            for (int s = 0; s < SLOTS; s++) begin
               if (pool_free[s] && pool_age[s] <= cutoff) begin
                  drop_slot(s);
                  r.evicted++;
               end
            end
         end else begin
            purge_cnt--;
         end
         frame_cnt++;
      end
      r.total = live_total;
      return r;
   endfunction

   function automatic surf_cmd_type make_cmd(logic [1:0] op, int am, int w, int h,
                                             int smp, int fmt, int fl, int tb, int rh);
      surf_cmd_type c;
      c.command     = op;
      c.attach_mask = 3'(am);
      c.width       = 15'(w);
      c.height      = 15'(h);
      c.samples     = 8'(smp);
      c.format      = 8'(fmt);
      c.flags       = 8'(fl);
      c.texel_bytes = 5'(tb);
      c.ret_handle  = 6'(rh);
      return c;
   endfunction

   function automatic int pick_small(int a, int b, int c);
      case ($urandom_range(0, 3))
         0: return a;
         1: return b;
         2: return c;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 16384);
         1: return $urandom_range(0, 32767);
         default: return $urandom_range(1, 4) * 32 - $urandom_range(0, 31);
      endcase
   endfunction

   // Random command drawn from the current shadow state, so that most puts
   // hand back surfaces that are really out.
   function automatic surf_cmd_type random_cmd();
      surf_cmd_type c;
      int        roll, out_list[$];
      c    = make_cmd(CMD_GET, $urandom_range(0, 7), pick_dim(), pick_dim(),
                      pick_small(0, 1, 4), pick_small(0, 7, 255), pick_small(0, 3, 255),
                      $urandom_range(0, 16), $urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 75 && $urandom_range(0, 1)) c.attach_mask = 3'd1;
      if (fill_mode) begin
         if (roll >= 90) c.command = CMD_PUT;
         else if (roll >= 85) c.command = CMD_GC;
      end else if (roll >= 98) begin
         c.command = CMD_BAD;
      end else if (roll >= 84) begin
         c.command = CMD_GC;
      end else if (roll >= 48) begin
         c.command = CMD_PUT;
      end
      if (c.command == CMD_PUT && $urandom_range(0, 99) < 85) begin
         foreach (pool_live[s]) if (pool_live[s] && !pool_free[s]) out_list.push_back(s);
         if (out_list.size() > 0)
            c.ret_handle = 6'(out_list[$urandom_range(0, out_list.size() - 1)]);
      end
      return c;
   endfunction

   function automatic void check_rsp(surf_rsp_type got, surf_rsp_type exp_r);
      if (got.handle !== exp_r.handle) begin
         $error("handle: expected %0d, got %0d", exp_r.handle, got.handle);
         error_count++;
      end
      if (got.reused !== exp_r.reused) begin
         $error("reused: expected %0d, got %0d", exp_r.reused, got.reused);
         error_count++;
      end
      if (got.status !== exp_r.status) begin
         $error("status: expected %0d, got %0d", exp_r.status, got.status);
         error_count++;
      end
      if (got.granted_w !== exp_r.granted_w) begin
         $error("granted_width: expected %0d, got %0d", exp_r.granted_w, got.granted_w);
         error_count++;
      end
      if (got.granted_h !== exp_r.granted_h) begin
         $error("granted_height: expected %0d, got %0d", exp_r.granted_h, got.granted_h);
         error_count++;
      end
      if (got.evicted !== exp_r.evicted) begin
         $error("evicted_count: expected %0d, got %0d", exp_r.evicted, got.evicted);
         error_count++;
      end
      if (got.total !== exp_r.total) begin
         $error("total_bytes: expected %0d, got %0d", exp_r.total, got.total);
         error_count++;
      end
   endfunction

   // Sender: predicts each accepted transfer, then offers the next command.
   initial begin
      surf_cmd_type  cur;
      surf_rsp_type  pred;
      int         gap;
      bit         next_valid;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_GET;
      gap = 0;
      forever begin
         @(posedge clock);
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            pred = pool_apply(cur);
            if (use_table && dir_rows[tbl_pos - 1].typed)
               pending_rsp.push_back(dir_rows[tbl_pos - 1].rsp);
            else
               pending_rsp.push_back(pred);
            items_left--;
            next_valid = 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
         end
         if (!idle_on) gap = 0;
         if (!next_valid && !reset && items_left > 0) begin
            if (gap > 0) begin
               gap--;
            end else begin
               if (use_table) begin
                  cur = dir_rows[tbl_pos].cmd;
                  tbl_pos++;
               end else begin
                  cur = random_cmd();
               end
               req_tdata  <= {4'b0, cur.ret_handle, cur.texel_bytes, cur.flags, cur.format,
                              cur.samples, cur.height, cur.width, cur.attach_mask};
               req_tuser  <= cur.command;
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Receiver: checks each result transfer and stalls at random.
   initial begin
      surf_rsp_type got;
      int        stall, hold;
      rsp_tready <= 1'b0;
      stall = 0;
      hold  = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = '{handle: rsp_tdata[5:0], reused: rsp_tdata[6], status: rsp_tuser,
                    granted_w: rsp_tdata[21:7], granted_h: rsp_tdata[36:22],
                    evicted: rsp_tdata[43:37], total: rsp_tdata[91:44]};
            if (pending_rsp.size() == 0) begin
               $error("unexpected result transfer, handle %0d", got.handle);
               error_count++;
            end else begin
               check_rsp(got, pending_rsp.pop_front());
            end
         end
         if (hold_req) begin
            hold_req = 1'b0;
            hold     = 400;
         end
         if (!idle_on) stall = 0;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !reset;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [47:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_MAX_FREE) lim_free = value[6:0];
      else if (idx == CSR_MAX_BYTES) lim_bytes = value;
      else if (idx == CSR_MAX_AGE) lim_age = value[31:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_batch(int n);
      items_left = n;
      wait (items_left == 0 && pending_rsp.size() == 0);
      repeat (10) @(posedge clock);
   endtask

   function automatic void add_row(surf_cmd_type c, bit typed, surf_rsp_type r);
      table_row_type row;
      row.cmd   = c;
      row.typed = typed;
      row.rsp   = r;
      dir_rows.push_back(row);
   endfunction

   initial begin
      surf_rsp_type none;
      logic [6:0]  free_set  [NUM_PHASES];
      logic [47:0] bytes_set [NUM_PHASES];
      logic [31:0] age_set   [NUM_PHASES];
      free_set  = '{7'd0, 7'd64, 7'd3, 7'd8, 7'd16};
      bytes_set = '{48'd0, BYTE_MASK, 48'd100000, 48'd1 << 30, 48'd16777216};
      age_set   = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'd5, 32'd30};
      none = '0;
      reset     <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_MAX_FREE;
      csr_wdata <= '0;
      pool_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table: reset state, extremes, error codes and reuse.
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 5), 1'b1,
              '{handle: 6'd5, status: STAT_BAD_PUT, default: '0});
      add_row(make_cmd(CMD_GET, 1, 1, 1, 0, 0, 0, 4, 0), 1'b1,
              '{granted_w: 15'd32, granted_h: 15'd32, total: 48'd4096, default: '0});
      add_row(make_cmd(CMD_BAD, 7, 32767, 32767, 255, 255, 255, 31, 63), 1'b1,
              '{total: 48'd4096, default: '0});
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_PUT, 7, 32767, 32767, 255, 255, 255, 31, 63), 1'b0, none);
      add_row(make_cmd(CMD_GET, 1, 20, 31, 1, 0, 0, 4, 0), 1'b0, none);
      add_row(make_cmd(CMD_GET, 7, 16384, 16384, 255, 255, 255, 16, 0), 1'b0, none);
      add_row(make_cmd(CMD_GET, 7, 32767, 32767, 255, 255, 255, 31, 63), 1'b0, none);
      add_row(make_cmd(CMD_GET, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_GET, 2, 100, 50, 4, 9, 5, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 4), 1'b0, none);
      add_row(make_cmd(CMD_GET, 2, 90, 40, 4, 9, 5, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 4), 1'b0, none);
      add_row(make_cmd(CMD_GET, 2, 40, 40, 4, 9, 5, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, none);
      add_row(make_cmd(CMD_PUT, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0, none);
      add_row(make_cmd(CMD_GC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      add_row(make_cmd(CMD_GC, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      use_table = 1'b1;
      run_batch(dir_rows.size());
      use_table = 1'b0;

      // Random phases, each with its own register setting; the last one also
      // runs without idling, and the second is mostly gets, to fill the handles.
      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(CSR_MAX_FREE, 48'(free_set[p]));
         csr_write(CSR_MAX_BYTES, bytes_set[p]);
         csr_write(CSR_MAX_AGE, 48'(age_set[p]));
         fill_mode = (p == 1);
         idle_on   = (p != NUM_PHASES - 1);
         if (p == 2) hold_req = 1'b1;
         run_batch(PHASE_ITEMS);
      end

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
